[hdl/fpme_pkg.sv]
// fpme_pkg: shared command codes, widths and controller/datapath interface types
`default_nettype none

package fpme_pkg;

	// field widths
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 4;
	localparam int WORD_W  = 32;
	localparam int FRAC_W  = 12;
	localparam int ACC_W   = WORD_W + FRAC_W;
	localparam int ROW_W   = 4 * WORD_W;
	localparam int S_DATA_W = 104;

	// fixed-point one in 20.12
	localparam logic [WORD_W-1:0] MTX_ONE = 32'd4096;

	// command codes
	localparam logic [CMD_W-1:0] CMD_IDENT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SCALE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TRANS = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MUL   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic             accept;
		logic             ident_clr;
		logic             load_wr;
		logic             issue;
		logic [IDX_W-1:0] issue_idx;
		logic             out_load;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pipe_busy;
	} dp_status_t;

endpackage

`default_nettype wire

[hdl/fixed_point_matrix_engine.sv]
// fixed_point_matrix_engine: top level of the 4x4 signed 20.12 matrix engine
//
// One request on the s_ channel carries a command in s_tuser and the element
// index and x, y, z words in s_tdata. Every request gives exactly one result on
// the m_ channel: m_tdata is the current element for a read, zero otherwise;
// m_tuser is high for a read.
// The block takes one request at a time; s_tready is high only while idle.
// Identity, load and read pass one state of their own and the finish state
// before the result register; unused codes go straight to the finish state.
// Scale, translate and multiply issue all sixteen elements in turn (one dot
// product of four terms a cycle on four shared multipliers), then pass the
// three stage product and add pipeline, a wait until it is empty, and the
// result register.
// A new request is taken only once the last result is in the output register.
// A result waiting on a stalled m_tready stays in the output register; the
// next request can be taken and its result waits until the register frees.
// Reset needs no clearing pass: the current matrix reads as identity and the
// operand as zero through per-row and per-element valid bits.
`default_nettype none

module fixed_point_matrix_engine (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,   // elem_index[3:0], x_value, y_value, z_value, zero pad
	input  wire logic [2:0]   s_tuser,   // command
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,   // read_value
	output logic              m_tuser    // was_read
);
	import fpme_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	fpme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	fpme_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.command    (s_tuser),
		.elem_index (s_tdata[3:0]),
		.x_value    (s_tdata[35:4]),
		.y_value    (s_tdata[67:36]),
		.z_value    (s_tdata[99:68]),
		.read_value (m_tdata),
		.was_read   (m_tuser)
	);

endmodule

`default_nettype wire

[hdl/fpme_ctrl.sv]
// fpme_ctrl: command sequencer and output handshake for the matrix engine
`default_nettype none

module fpme_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [fpme_pkg::CMD_W-1:0] command,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output fpme_pkg::ctrl_cmd_t            ctl,
	input  wire fpme_pkg::dp_status_t      sts
);
	import fpme_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLR   = 3'd1;
	localparam logic [2:0] S_WR    = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             out_vld_q;
	logic             accept;
	logic             out_load;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_FIN) && (!out_vld_q || m_tready);
	assign m_tvalid = out_vld_q;

	// commands to the datapath
	always_comb begin
		ctl.accept    = accept;
		ctl.ident_clr = (state_q == S_CLR);
		ctl.load_wr   = (state_q == S_WR);
		ctl.issue     = (state_q == S_MUL);
		ctl.issue_idx = cnt_q;
		ctl.out_load  = out_load;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_IDENT: state_d = S_CLR;
						CMD_LOAD:  state_d = S_WR;
						CMD_READ:  state_d = S_RD;
						CMD_SCALE, CMD_TRANS, CMD_MUL: state_d = S_MUL;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_CLR, S_WR, S_RD: state_d = S_FIN;
			S_MUL: begin
				if (cnt_q == '1) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, element counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL) cnt_q <= cnt_q + 1'b1;
			if (out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[hdl/fpme_datapath.sv]
// fpme_datapath: matrix stores, four-multiplier dot product pipeline and result register
`default_nettype none

module fpme_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fpme_pkg::ctrl_cmd_t         ctl,
	output fpme_pkg::dp_status_t             sts,
	input  wire logic [fpme_pkg::CMD_W-1:0]  command,
	input  wire logic [fpme_pkg::IDX_W-1:0]  elem_index,
	input  wire logic [fpme_pkg::WORD_W-1:0] x_value,
	input  wire logic [fpme_pkg::WORD_W-1:0] y_value,
	input  wire logic [fpme_pkg::WORD_W-1:0] z_value,
	output logic [fpme_pkg::WORD_W-1:0]      read_value,
	output logic                             was_read
);
	import fpme_pkg::*;

	// identity row r: one at word r
	function automatic logic [ROW_W-1:0] ident_row(input logic [1:0] r);
		logic [ROW_W-1:0] row;
		row = '0;
		row[{r, 5'd0} +: WORD_W] = MTX_ONE;
		return row;
	endfunction

	// column c of the scale or translate matrix, word k is element c+4k
	function automatic logic [ROW_W-1:0] gen_column(
		input logic [CMD_W-1:0]  cmd,
		input logic [1:0]        c,
		input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] y,
		input logic [WORD_W-1:0] z
	);
		logic [ROW_W-1:0]  col;
		logic [WORD_W-1:0] val;
		col = '0;
		unique case (c)
			2'd0: val = x;
			2'd1: val = y;
			2'd2: val = z;
			default: val = MTX_ONE;
		endcase
		if (cmd == CMD_SCALE) begin
			col[{c, 5'd0} +: WORD_W] = val;
		end else begin
			col[{c, 5'd0} +: WORD_W] = MTX_ONE;
			if (c != 2'd3) col[3*WORD_W +: WORD_W] = val;
		end
		return col;
	endfunction

	// latched request
	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] x_q, y_q, z_q;

	// current matrix: one row per word, operand: one column per word
	logic [ROW_W-1:0] cur_mem [4];
	logic [3:0]       cur_vld_q;
	logic [ROW_W-1:0] opnd_mem [4];
	logic [15:0]      opnd_vld_q;

	// pipeline
	logic [1:0]       cur_raddr;
	logic [1:0]       col_addr;
	logic [ROW_W-1:0] cur_rd_s1, opnd_rd_s1, gen_s1;
	logic             cur_vld_s1;
	logic [3:0]       opnd_vld_s1;
	logic [1:0]       raddr_s1;
	logic [IDX_W-1:0] rc_s1, rc_s2, rc_s3;
	logic             v_s1, v_s2, v_s3;
	logic [ROW_W-1:0] brow_s1, acol_s1;
	logic signed [2*WORD_W-1:0] prod [4];
	logic [ACC_W-1:0] prod_s2 [4];
	logic [ACC_W-1:0] psum_s3 [2];
	logic [ACC_W-1:0] sum;
	logic [WORD_W-1:0] res;
	logic [3*WORD_W-1:0] rowbuf_q;
	logic [WORD_W-1:0] rd_word;
	logic             is_read;

	assign cur_raddr = ctl.issue ? ctl.issue_idx[3:2] : idx_q[3:2];
	assign col_addr  = ctl.issue_idx[1:0];
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;

	// request latch
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= command;
			idx_q <= elem_index;
			x_q   <= x_value;
			y_q   <= y_value;
			z_q   <= z_value;
		end
	end

	// operand store writes
	always_ff @(posedge clk) begin
		if (ctl.load_wr) opnd_mem[idx_q[1:0]][{idx_q[3:2], 5'd0} +: WORD_W] <= x_q;
	end

	// current store writes, a row at a time
	always_ff @(posedge clk) begin
		if (v_s3 && (rc_s3[1:0] == 2'd3)) cur_mem[rc_s3[3:2]] <= {res, rowbuf_q};
	end

	// valid bits: unwritten current rows read as identity, operand elements as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q  <= '0;
			opnd_vld_q <= '0;
		end else begin
			if (ctl.ident_clr) cur_vld_q <= '0;
			else if (v_s3 && (rc_s3[1:0] == 2'd3)) cur_vld_q[rc_s3[3:2]] <= 1'b1;
			if (ctl.load_wr) opnd_vld_q[idx_q] <= 1'b1;
		end
	end

	// stage 1: registered store reads and generated column
	always_ff @(posedge clk) begin
		cur_rd_s1  <= cur_mem[cur_raddr];
		cur_vld_s1 <= cur_vld_q[cur_raddr];
		raddr_s1   <= cur_raddr;
		opnd_rd_s1 <= opnd_mem[col_addr];
		for (int k = 0; k < 4; k++) begin
			opnd_vld_s1[k] <= opnd_vld_q[{2'(k), col_addr}];
		end
		gen_s1 <= gen_column(cmd_q, col_addr, x_q, y_q, z_q);
		rc_s1  <= ctl.issue_idx;
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// operand selection and the four products
	always_comb begin
		brow_s1 = cur_vld_s1 ? cur_rd_s1 : ident_row(raddr_s1);
		for (int k = 0; k < 4; k++) begin
			if (cmd_q == CMD_MUL) begin
				acol_s1[k*WORD_W +: WORD_W] =
					opnd_vld_s1[k] ? opnd_rd_s1[k*WORD_W +: WORD_W] : '0;
			end else begin
				acol_s1[k*WORD_W +: WORD_W] = gen_s1[k*WORD_W +: WORD_W];
			end
			prod[k] = $signed(acol_s1[k*WORD_W +: WORD_W]) *
				$signed(brow_s1[k*WORD_W +: WORD_W]);
		end
	end

	// stage 2: products, kept to the bits that reach the result
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s2[k] <= prod[k][ACC_W-1:0];
		end
		rc_s2 <= rc_s1;
	end

	// stage 3: pair sums
	always_ff @(posedge clk) begin
		psum_s3[0] <= prod_s2[0] + prod_s2[1];
		psum_s3[1] <= prod_s2[2] + prod_s2[3];
		rc_s3      <= rc_s2;
	end

	// final sum and fraction drop
	assign sum = psum_s3[0] + psum_s3[1];
	assign res = sum[ACC_W-1:FRAC_W];

	// collect the first three words of a result row
	always_ff @(posedge clk) begin
		if (v_s3 && (rc_s3[1:0] != 2'd3)) rowbuf_q[{rc_s3[1:0], 5'd0} +: WORD_W] <= res;
	end

	// result register
	assign is_read = (cmd_q == CMD_READ);
	assign rd_word = brow_s1[{idx_q[1:0], 5'd0} +: WORD_W];

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			read_value <= is_read ? rd_word : '0;
			was_read   <= is_read;
		end
	end

endmodule

`default_nettype wire

[hdl/fpme_checker.sv]
// fpme_checker: port-level assertions for the matrix engine and their bind
`default_nettype none

module fpme_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [103:0] s_tdata,
	input wire logic [2:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [31:0]  m_tdata,
	input wire logic         m_tuser
);
	import fpme_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// results other than reads carry zero
	a_zero_non_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("non-read result not zero");

	// a matrix product does not reopen the input straight away
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_MUL) |=> ##2 !s_tready)
		else $error("multiply finished too early");

endmodule

bind fixed_point_matrix_engine fpme_checker u_fpme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
